// ===== rtl/slot_pool_best_fit_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Slot pool allocator assertion macros
// Shared concurrent assertion forms for the slot pool allocator checkers.
// ----------------------------------------------------------------------------
`ifndef SLOT_POOL_BEST_FIT_ALLOCATOR_MACROS_SVH
`define SLOT_POOL_BEST_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SPBFA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SPBFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/spbfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Field widths, request and status codes and register map of the allocator.
// ----------------------------------------------------------------------------
package spbfa_pkg;

   localparam int MODE_W       = 2;
   localparam int AMOUNT_W     = 16;
   localparam int SLOT_INDEX_W = 6;
   localparam int COUNT_W      = 7;
   localparam int CFG_SLOTS_W  = 7;
   localparam int CFG_CAP_W    = 16;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_BEST_FIT  = 2'd0,
      MODE_FIRST_FIT = 2'd1,
      MODE_RELEASE   = 2'd2,
      MODE_NOP       = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_FULL        = 2'd1,
      STATUS_BAD_REQUEST = 2'd2,
      STATUS_NOT_FOUND   = 2'd3
   } status_type;

   // Register select is the word address bit of paddr.
   localparam logic REG_INITIAL_SLOTS    = 1'b0;
   localparam logic REG_INITIAL_CAPACITY = 1'b1;

   localparam logic [CFG_SLOTS_W-1:0] CFG_SLOTS_RESET = 7'd0;
   localparam logic [CFG_CAP_W-1:0]   CFG_CAP_RESET   = 16'd1;

endpackage

// ===== rtl/spbfa_channels.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator channels
// Valid/ready request and response interfaces with source and sink modports.
// ----------------------------------------------------------------------------
interface spbfa_req_if
   import spbfa_pkg::*;
();
   logic                    valid;
   logic                    ready;
   mode_type                mode;
   logic [AMOUNT_W-1:0]     amount;
   logic [SLOT_INDEX_W-1:0] slot_index;

   modport source (output valid, output mode, output amount, output slot_index,
                   input ready);
   modport sink   (input valid, input mode, input amount, input slot_index,
                   output ready);
endinterface

interface spbfa_rsp_if
   import spbfa_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [SLOT_INDEX_W-1:0] granted_slot;
   logic                    created;
   status_type              status;
   logic [COUNT_W-1:0]      free_slots;
   logic [COUNT_W-1:0]      total_slots;

   modport source (output valid, output granted_slot, output created, output status,
                   output free_slots, output total_slots, input ready);
   modport sink   (input valid, input granted_slot, input created, input status,
                   input free_slots, input total_slots, output ready);
endinterface

// ===== rtl/slot_pool_best_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// Slot pool best-fit allocator
// Hands out slots from a table by best fit or first fit and takes them back.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one request (mode, amount, slot_index); it is taken when
//   valid and ready are high at a clock edge. rsp_bus returns one response per
//   request in order. Writing initial_slots (0x0) or initial_capacity (0x4)
//   on the csr_ port rebuilds the table; csr_pready is always high.
// Sequencing:
//   One request at a time. A scan walks the slot memory one entry per cycle;
//   for best fit each free slot at least as large as the request also runs a
//   serial divider over the full capacity width before the scan moves on.
//   First fit stops at the first free slot that fits; release and rejects
//   skip the scan.
// Rebuild:
//   After a register write the block fills min(initial_slots, MAX_SLOTS)
//   entries, one per cycle, and holds req ready low until the fill is done.
// Reset:
//   Counts clear, registers reset, the table is empty, no response is pending.
//   The slot memory is not cleared; entries beyond the slot count are unread.
// Stall:
//   A response waits in the output register; the next request is still taken
//   and its response waits in the sequencer until the register frees up.
// ----------------------------------------------------------------------------
module slot_pool_best_fit_allocator
   import spbfa_pkg::*;
#(
   parameter int MAX_SLOTS     = 64,
   parameter int CAPACITY_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   spbfa_req_if.sink             req_bus,
   spbfa_rsp_if.source           rsp_bus
);

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int WORD_W = CAPACITY_BITS + 1;
   localparam int DIV_W  = (CAPACITY_BITS > AMOUNT_W) ? CAPACITY_BITS : AMOUNT_W;
   localparam int WIDE_W = DIV_W + 1;
   localparam int DCNT_W = $clog2(CAPACITY_BITS + 1);
   localparam int IDXC_W = (CNT_W > SLOT_INDEX_W) ? CNT_W : SLOT_INDEX_W;
   localparam int NS_W   = (CNT_W > CFG_SLOTS_W) ? CNT_W : CFG_SLOTS_W;

   localparam logic [WIDE_W-1:0] CAP_MAX_W =
      {{(WIDE_W - CAPACITY_BITS){1'b0}}, {CAPACITY_BITS{1'b1}}};
   localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(CAPACITY_BITS - 1);
   localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_SLOTS);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_FILL   = 7'b0000010,
      S_EVAL   = 7'b0000100,
      S_DIV    = 7'b0001000,
      S_FINISH = 7'b0010000,
      S_REL    = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   // Configuration registers
   logic [CFG_SLOTS_W-1:0] cfg_slots_ff;
   logic [CFG_CAP_W-1:0]   cfg_cap_ff;
   logic                   csr_write;

   // Slot memory: {free mark, capacity} per entry
   logic [WORD_W-1:0] slot_mem [MAX_SLOTS];
   logic [WORD_W-1:0] mem_rdata_ff;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [SLOT_W-1:0] mem_raddr;

   // Control state
   state_type  state_ff, state_in;
   logic [CNT_W-1:0] slot_count_ff, slot_count_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Working registers
   mode_type                mode_ff, mode_in;
   logic [AMOUNT_W-1:0]     amount_ff, amount_in;
   logic [SLOT_INDEX_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]        fill_idx_ff, fill_idx_in;
   logic                    found_ff, found_in;
   logic [CAPACITY_BITS-1:0] best_q_ff, best_q_in;
   logic [SLOT_W-1:0]       pick_ff, pick_in;
   logic [CAPACITY_BITS-1:0] pick_cap_ff, pick_cap_in;
   logic [DIV_W-1:0]        div_rem_ff, div_rem_in;
   logic [CAPACITY_BITS-1:0] div_quot_ff, div_quot_in;
   logic [DCNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic [SLOT_W-1:0]       res_granted_ff, res_granted_in;
   logic                    res_created_ff, res_created_in;
   status_type              res_status_ff, res_status_in;

   // Output register
   logic [SLOT_INDEX_W-1:0] rsp_granted_ff, rsp_granted_in;
   logic                    rsp_created_ff, rsp_created_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]      rsp_free_ff, rsp_free_in;
   logic [COUNT_W-1:0]      rsp_total_ff, rsp_total_in;

   // Datapath helpers
   logic                     rd_free;
   logic [CAPACITY_BITS-1:0] rd_cap;
   logic                     rd_fits;
   logic                     scan_last;
   logic [SLOT_W-1:0]        scan_next;
   logic [WIDE_W-1:0]        rem_shift;
   logic [WIDE_W-1:0]        rem_sub;
   logic                     div_ge;
   logic [DIV_W-1:0]         div_rem_step;
   logic [CAPACITY_BITS-1:0] div_quot_step;
   logic [WIDE_W-1:0]        app_wide;
   logic [CAPACITY_BITS-1:0] app_cap;
   logic [WIDE_W-1:0]        fill_wide;
   logic [CAPACITY_BITS-1:0] fill_cap;
   logic [CNT_W-1:0]         fill_n;
   logic                     req_idx_ok;

   // ------------------------------------------------------------------------
   // Configuration port: write on the access phase, reads are combinational.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_slots_ff <= CFG_SLOTS_RESET;
         cfg_cap_ff   <= CFG_CAP_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[CSR_ADDR_W-1])
            REG_INITIAL_SLOTS:    cfg_slots_ff <= csr_pwdata[CFG_SLOTS_W-1:0];
            REG_INITIAL_CAPACITY: cfg_cap_ff   <= csr_pwdata[CFG_CAP_W-1:0];
            default:              cfg_slots_ff <= cfg_slots_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[CSR_ADDR_W-1])
         REG_INITIAL_SLOTS:    csr_prdata = CSR_DATA_W'(cfg_slots_ff);
         REG_INITIAL_CAPACITY: csr_prdata = CSR_DATA_W'(cfg_cap_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Slot memory: one write port, one registered read port.
   // A write always lands before the next read of the
   // same entry, so no forwarding path is needed.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= slot_mem[mem_raddr];
   end

   assign rd_free = mem_rdata_ff[CAPACITY_BITS];
   assign rd_cap  = mem_rdata_ff[CAPACITY_BITS-1:0];
   assign rd_fits = rd_free && (WIDE_W'(rd_cap) >= WIDE_W'(amount_ff));

   // Scan bookkeeping
   assign scan_last = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == slot_count_ff);
   assign scan_next = scan_idx_ff + SLOT_W'(1);

   // Restoring divider step: one quotient bit per cycle, MSB first.
   assign rem_shift     = {div_rem_ff, div_quot_ff[CAPACITY_BITS-1]};
   assign rem_sub       = rem_shift - WIDE_W'(amount_ff);
   assign div_ge        = (rem_shift >= WIDE_W'(amount_ff));
   assign div_rem_step  = div_ge ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
   assign div_quot_step = {div_quot_ff[CAPACITY_BITS-2:0], div_ge};

   // Appended capacity: the size for best fit, length plus one for first fit,
   // saturated to the capacity width.
   assign app_wide = WIDE_W'(amount_ff)
                   + ((mode_ff == MODE_FIRST_FIT) ? WIDE_W'(1) : WIDE_W'(0));
   assign app_cap  = (app_wide > CAP_MAX_W) ? CAP_MAX_W[CAPACITY_BITS-1:0]
                                            : app_wide[CAPACITY_BITS-1:0];

   // Rebuild values, saturated to the table depth and capacity width.
   assign fill_wide = WIDE_W'(cfg_cap_ff);
   assign fill_cap  = (fill_wide > CAP_MAX_W) ? CAP_MAX_W[CAPACITY_BITS-1:0]
                                              : fill_wide[CAPACITY_BITS-1:0];
   assign fill_n    = (NS_W'(cfg_slots_ff) > NS_W'(MAX_SLOTS)) ? MAX_COUNT
                                                               : CNT_W'(cfg_slots_ff);

   assign req_idx_ok = (IDXC_W'(req_bus.slot_index) < IDXC_W'(slot_count_ff));

   assign req_bus.ready = (state_ff == S_IDLE);

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      slot_count_in  = slot_count_ff;
      free_count_in  = free_count_ff;
      mode_in        = mode_ff;
      amount_in      = amount_ff;
      idx_in         = idx_ff;
      scan_idx_in    = scan_idx_ff;
      fill_idx_in    = fill_idx_ff;
      found_in       = found_ff;
      best_q_in      = best_q_ff;
      pick_in        = pick_ff;
      pick_cap_in    = pick_cap_ff;
      div_rem_in     = div_rem_ff;
      div_quot_in    = div_quot_ff;
      div_cnt_in     = div_cnt_ff;
      res_granted_in = res_granted_ff;
      res_created_in = res_created_ff;
      res_status_in  = res_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_created_in = rsp_created_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      // Keep reading the current scan entry so its data stays put while the
      // divider runs.
      mem_raddr      = scan_idx_ff;
      mem_we         = 1'b0;
      mem_waddr      = scan_idx_ff;
      mem_wdata      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               mode_in        = req_bus.mode;
               amount_in      = req_bus.amount;
               idx_in         = req_bus.slot_index;
               scan_idx_in    = '0;
               found_in       = 1'b0;
               res_granted_in = '0;
               res_created_in = 1'b0;
               res_status_in  = STATUS_OK;
               mem_raddr      = '0;
               unique case (req_bus.mode)
                  MODE_BEST_FIT, MODE_FIRST_FIT: begin
                     if ((req_bus.mode == MODE_BEST_FIT) && (req_bus.amount == '0)) begin
                        res_status_in = STATUS_BAD_REQUEST;
                        state_in      = S_DONE;
                     end else if (slot_count_ff == '0) begin
                        state_in = S_FINISH;
                     end else begin
                        state_in = S_EVAL;
                     end
                  end
                  MODE_RELEASE: begin
                     if (req_idx_ok) begin
                        mem_raddr = SLOT_W'(req_bus.slot_index);
                        state_in  = S_REL;
                     end else begin
                        res_status_in = STATUS_NOT_FOUND;
                        state_in      = S_DONE;
                     end
                  end
                  MODE_NOP: state_in = S_DONE;
                  default:  state_in = S_DONE;
               endcase
            end
         end

         S_EVAL: begin
            if (rd_fits && (mode_ff == MODE_FIRST_FIT)) begin
               found_in    = 1'b1;
               pick_in     = scan_idx_ff;
               pick_cap_in = rd_cap;
               state_in    = S_FINISH;
            end else if (rd_fits) begin
               div_rem_in  = '0;
               div_quot_in = rd_cap;
               div_cnt_in  = '0;
               state_in    = S_DIV;
            end else if (scan_last) begin
               state_in = S_FINISH;
            end else begin
               scan_idx_in = scan_next;
               mem_raddr   = scan_next;
            end
         end

         S_DIV: begin
            div_rem_in  = div_rem_step;
            div_quot_in = div_quot_step;
            div_cnt_in  = div_cnt_ff + DCNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               // Strict compare keeps the lowest index on a tie.
               if (!found_ff || (div_quot_step < best_q_ff)) begin
                  found_in    = 1'b1;
                  best_q_in   = div_quot_step;
                  pick_in     = scan_idx_ff;
                  pick_cap_in = rd_cap;
               end
               if (scan_last) begin
                  state_in = S_FINISH;
               end else begin
                  scan_idx_in = scan_next;
                  mem_raddr   = scan_next;
                  state_in    = S_EVAL;
               end
            end
         end

         S_FINISH: begin
            state_in = S_DONE;
            if (found_ff) begin
               mem_we         = 1'b1;
               mem_waddr      = pick_ff;
               mem_wdata      = {1'b0, pick_cap_ff};
               free_count_in  = free_count_ff - CNT_W'(1);
               res_granted_in = pick_ff;
            end else if (slot_count_ff < MAX_COUNT) begin
               mem_we         = 1'b1;
               mem_waddr      = slot_count_ff[SLOT_W-1:0];
               mem_wdata      = {1'b0, app_cap};
               slot_count_in  = slot_count_ff + CNT_W'(1);
               res_granted_in = slot_count_ff[SLOT_W-1:0];
               res_created_in = 1'b1;
            end else begin
               res_status_in = STATUS_FULL;
            end
         end

         S_REL: begin
            // Keep the capacity, set the free mark; count only a used slot.
            mem_we         = 1'b1;
            mem_waddr      = SLOT_W'(idx_ff);
            mem_wdata      = {1'b1, rd_cap};
            res_granted_in = SLOT_W'(idx_ff);
            if (!rd_free) begin
               free_count_in = free_count_ff + CNT_W'(1);
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = SLOT_INDEX_W'(res_granted_ff);
               rsp_created_in = res_created_ff;
               rsp_status_in  = res_status_ff;
               rsp_free_in    = COUNT_W'(free_count_ff);
               rsp_total_in   = COUNT_W'(slot_count_ff);
               state_in       = S_IDLE;
            end
         end

         S_FILL: begin
            if (fill_idx_ff == fill_n) begin
               slot_count_in = fill_n;
               free_count_in = fill_n;
               state_in      = S_IDLE;
            end else begin
               mem_we      = 1'b1;
               mem_waddr   = fill_idx_ff[SLOT_W-1:0];
               mem_wdata   = {1'b1, fill_cap};
               fill_idx_in = fill_idx_ff + CNT_W'(1);
            end
         end

         default: state_in = S_IDLE;
      endcase

      // A register write restarts the rebuild from the first entry.
      if (csr_write) begin
         state_in    = S_FILL;
         fill_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_count_ff <= '0;
         free_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_count_ff <= slot_count_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      amount_ff      <= amount_in;
      idx_ff         <= idx_in;
      scan_idx_ff    <= scan_idx_in;
      fill_idx_ff    <= fill_idx_in;
      found_ff       <= found_in;
      best_q_ff      <= best_q_in;
      pick_ff        <= pick_in;
      pick_cap_ff    <= pick_cap_in;
      div_rem_ff     <= div_rem_in;
      div_quot_ff    <= div_quot_in;
      div_cnt_ff     <= div_cnt_in;
      res_granted_ff <= res_granted_in;
      res_created_ff <= res_created_in;
      res_status_ff  <= res_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_created_ff <= rsp_created_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.granted_slot = rsp_granted_ff;
   assign rsp_bus.created      = rsp_created_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.free_slots   = rsp_free_ff;
   assign rsp_bus.total_slots  = rsp_total_ff;

endmodule

// ===== rtl/spbfa_checker.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator checker
// Port-level assertions on responses and rebuild behavior, bound to the top.
// ----------------------------------------------------------------------------
`include "slot_pool_best_fit_allocator_macros.svh"

module spbfa_checker
   import spbfa_pkg::*;
#(
   parameter int MAX_SLOTS = 64
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    csr_psel,
   input logic                    csr_penable,
   input logic                    csr_pwrite,
   input logic                    csr_pready,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [SLOT_INDEX_W-1:0] rsp_granted_slot,
   input logic                    rsp_created,
   input status_type              rsp_status,
   input logic [COUNT_W-1:0]      rsp_free_slots,
   input logic [COUNT_W-1:0]      rsp_total_slots
);

   // Hold a stalled response.
   `SPBFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_granted_slot) && $stable(rsp_created) && $stable(rsp_status) && $stable(rsp_free_slots) && $stable(rsp_total_slots), "stalled response changed")

   // A rejected request hands out nothing.
   `SPBFA_ASSERT_IMPLY(a_reject_empty, clock, reset, rsp_valid && (rsp_status != STATUS_OK), (rsp_granted_slot == '0) && !rsp_created, "rejected request carries a slot")

   // Only a successful acquire appends a slot.
   `SPBFA_ASSERT_IMPLY(a_created_ok, clock, reset, rsp_valid && rsp_created, rsp_status == STATUS_OK, "slot created with error status")

   // Free slots never exceed the table size while the counts are not masked.
   `SPBFA_ASSERT_IMPLY(a_free_le_total, clock, reset, rsp_valid, (MAX_SLOTS > 127) || (rsp_free_slots <= rsp_total_slots), "free count above total")

   // A register write starts a rebuild that blocks requests.
   `SPBFA_ASSERT_NEXT(a_rebuild_blocks, clock, reset, csr_psel && csr_penable && csr_pwrite && csr_pready, !req_ready, "request taken during rebuild")

endmodule

bind slot_pool_best_fit_allocator spbfa_checker #(
   .MAX_SLOTS (MAX_SLOTS)
) u_spbfa_checker (
   .clock            (clock),
   .reset            (reset),
   .csr_psel         (csr_psel),
   .csr_penable      (csr_penable),
   .csr_pwrite       (csr_pwrite),
   .csr_pready       (csr_pready),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_granted_slot (rsp_bus.granted_slot),
   .rsp_created      (rsp_bus.created),
   .rsp_status       (rsp_bus.status),
   .rsp_free_slots   (rsp_bus.free_slots),
   .rsp_total_slots  (rsp_bus.total_slots)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator testbench
// Drives best-fit, first-fit, release and idle requests into the allocator,
// rebuilds the table through the csr_ port between phases, and checks every
// response field against an in-bench model of the slot table.
// ----------------------------------------------------------------------------
module tb;
   import spbfa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SLOTS     = 64;
   localparam int CAPACITY_BITS = 16;
   localparam logic [CAPACITY_BITS-1:0] CAP_MAX = '1;

   // Byte addresses of the two registers: word select sits above the byte bits.
   localparam logic [CSR_ADDR_W-1:0] ADDR_INITIAL_SLOTS    = {REG_INITIAL_SLOTS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_INITIAL_CAPACITY = {REG_INITIAL_CAPACITY, 2'b00};

   // Watch time after the final drain, longer than the worst best-fit scan.
   localparam int DRAIN_CYCLES = 1200;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 68;
   // Timeout: several times the slowest legal run of every request.
   localparam longint LIMIT_NS = 64'd60_000_000;

   typedef struct {
      logic [SLOT_INDEX_W-1:0] granted_slot;
      logic                    created;
      status_type              status;
      logic [COUNT_W-1:0]      free_slots;
      logic [COUNT_W-1:0]      total_slots;
   } grant_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   spbfa_req_if req_ch ();
   spbfa_rsp_if rsp_ch ();

   slot_pool_best_fit_allocator #(
      .MAX_SLOTS     (MAX_SLOTS),
      .CAPACITY_BITS (CAPACITY_BITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_bus     (req_ch),
      .rsp_bus     (rsp_ch)
   );

   // Slot table model: capacities, free marks and counts, plus the registers.
   logic [CAPACITY_BITS-1:0] pool_cap [MAX_SLOTS];
   bit                       pool_free [MAX_SLOTS];
   int unsigned              pool_total;
   int unsigned              pool_free_cnt;
   logic [CFG_SLOTS_W-1:0]   cfg_slots;
   logic [CFG_CAP_W-1:0]     cfg_cap;

   grant_type pending_grants [$];

   int mismatches;
   int responses_checked;
   int best_fit_sent, first_fit_sent, release_sent, nop_sent;
   int slots_created, full_seen;
   int burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("timeout at %0t ns with %0d responses outstanding", $time,
               pending_grants.size());
      $display("FAILED: results differ");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Model of the slot table
   // ------------------------------------------------------------------------

   // Rebuild: initial_slots free slots of initial_capacity, capped at the table.
   function automatic void rebuild_pool();
      int unsigned n;
      n = (cfg_slots > MAX_SLOTS) ? MAX_SLOTS : cfg_slots;
      for (int i = 0; i < n; i++) begin
         pool_cap[i]  = cfg_cap;
         pool_free[i] = 1'b1;
      end
      pool_total    = n;
      pool_free_cnt = n;
   endfunction

   // Append a used slot at the end of the table; refuse when the table is full.
   function automatic bit append_slot(logic [CAPACITY_BITS-1:0] cap,
                                      output logic [SLOT_INDEX_W-1:0] where);
      where = '0;
      if (pool_total >= MAX_SLOTS) return 1'b0;
      pool_cap[pool_total]  = cap;
      pool_free[pool_total] = 1'b0;
      where                 = pool_total[SLOT_INDEX_W-1:0];
      pool_total++;
      return 1'b1;
   endfunction

   // Apply one request to the model and return the response it must produce.
   function automatic grant_type predict_grant(mode_type m, logic [AMOUNT_W-1:0] amt,
                                               logic [SLOT_INDEX_W-1:0] idx);
      grant_type                r;
      bit                       found;
      int unsigned              q, best, pick;
      logic [CAPACITY_BITS-1:0] grow;
      r.granted_slot = '0;
      r.created      = 1'b0;
      r.status       = STATUS_OK;
      found          = 1'b0;
      best           = 0;
      pick           = 0;
      case (m)
         MODE_BEST_FIT: begin
            if (amt == '0) begin
               r.status = STATUS_BAD_REQUEST;
            end else begin
               // Smallest quotient of at least one wins; strict compare keeps the
               // lowest index on a tie.
               for (int i = 0; i < pool_total; i++) begin
                  if (pool_free[i]) begin
                     q = 32'(pool_cap[i]) / 32'(amt);
                     if (q >= 1 && (!found || q < best)) begin
                        found = 1'b1;
                        best  = q;
                        pick  = i;
                     end
                  end
               end
               if (found) begin
                  pool_free[pick] = 1'b0;
                  pool_free_cnt--;
                  r.granted_slot = pick[SLOT_INDEX_W-1:0];
               end else if (append_slot(amt, r.granted_slot)) begin
                  r.created = 1'b1;
               end else begin
                  r.status = STATUS_FULL;
               end
            end
         end
         MODE_FIRST_FIT: begin
            for (int i = 0; i < pool_total; i++) begin
               if (!found && pool_free[i] && amt <= pool_cap[i]) begin
                  found = 1'b1;
                  pick  = i;
               end
            end
            // Room for the terminator, saturated at the widest capacity.
            grow = (amt == CAP_MAX) ? CAP_MAX : amt + 1'b1;
            if (found) begin
               pool_free[pick] = 1'b0;
               pool_free_cnt--;
               r.granted_slot = pick[SLOT_INDEX_W-1:0];
            end else if (append_slot(grow, r.granted_slot)) begin
               r.created = 1'b1;
            end else begin
               r.status = STATUS_FULL;
            end
         end
         MODE_RELEASE: begin
            if (idx < pool_total) begin
               if (!pool_free[idx]) begin
                  pool_free[idx] = 1'b1;
                  pool_free_cnt++;
               end
               r.granted_slot = idx;
            end else begin
               r.status = STATUS_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
      r.free_slots  = pool_free_cnt[COUNT_W-1:0];
      r.total_slots = pool_total[COUNT_W-1:0];
      return r;
   endfunction

   // Queue a predicted response behind the ones still outstanding.
   function automatic void queue_grant(grant_type g);
      pending_grants.insert(pending_grants.size(), g);
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Send one request, record its response in the model, then either keep valid
   // high for the next request of the burst or drop it for a random gap.
   task automatic send_request(mode_type m, logic [AMOUNT_W-1:0] amt,
                               logic [SLOT_INDEX_W-1:0] idx);
      int gap;
      @(negedge clock);
      req_ch.valid      = 1'b1;
      req_ch.mode       = m;
      req_ch.amount     = amt;
      req_ch.slot_index = idx;
      do @(posedge clock); while (!req_ch.ready);
      queue_grant(predict_grant(m, amt, idx));
      case (m)
         MODE_BEST_FIT:  best_fit_sent++;
         MODE_FIRST_FIT: first_fit_sent++;
         MODE_RELEASE:   release_sent++;
         default:        nop_sent++;
      endcase
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         // Mostly short bursts, now and then a long run without idle cycles.
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // Drop valid and wait for every outstanding response to come back.
   task automatic drain_requests();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
   endtask

   // Two-phase register write; the model rebuilds as the block does. Hold off
   // until the block has finished filling the table and takes requests again.
   task automatic write_register(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_INITIAL_SLOTS) cfg_slots = data[CFG_SLOTS_W-1:0];
      else cfg_cap = data[CFG_CAP_W-1:0];
      rebuild_pool();
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      repeat (2) @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Rebuild the table with a new count and capacity, in random register order.
   // Unused upper data bits carry noise, which the block must ignore.
   task automatic set_pool(int unsigned slots, int unsigned cap);
      logic [CSR_DATA_W-1:0] slots_word, cap_word;
      slots_word = {$urandom} & ~32'h7F | (slots & 32'h7F);
      cap_word   = {$urandom} & ~32'hFFFF | (cap & 32'hFFFF);
      drain_requests();
      if ($urandom_range(0, 1)) begin
         write_register(ADDR_INITIAL_SLOTS, slots_word);
         write_register(ADDR_INITIAL_CAPACITY, cap_word);
      end else begin
         write_register(ADDR_INITIAL_CAPACITY, cap_word);
         write_register(ADDR_INITIAL_SLOTS, slots_word);
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // Receiver ready: switch among stall styles, each held for a random span.
   initial begin
      int style, span, tick;
      rsp_ch.ready = 1'b0;
      tick = 0;
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(20, 200);
         repeat (span) begin
            @(negedge clock);
            tick++;
            case (style)
               0: rsp_ch.ready = 1'b1;
               1: rsp_ch.ready = 1'($urandom_range(0, 1));
               2: rsp_ch.ready = (tick % 4) == 0;
               default: rsp_ch.ready = (tick % 25) == 0;
            endcase
         end
      end
   end

   // Compare each accepted response with the oldest outstanding prediction.
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_grants.size() == 0) begin
            mismatches++;
            $display("%0t ns: response with none outstanding: slot %0d status %0d",
                     $time, rsp_ch.granted_slot, rsp_ch.status);
         end else begin
            want = pending_grants.pop_front();
            responses_checked++;
            if (rsp_ch.granted_slot !== want.granted_slot) begin
               mismatches++;
               $display("%0t ns: granted_slot expected %0d actual %0d", $time,
                        want.granted_slot, rsp_ch.granted_slot);
            end
            if (rsp_ch.created !== want.created) begin
               mismatches++;
               $display("%0t ns: created expected %0b actual %0b", $time,
                        want.created, rsp_ch.created);
            end
            if (rsp_ch.status !== want.status) begin
               mismatches++;
               $display("%0t ns: status expected %0d actual %0d", $time,
                        want.status, rsp_ch.status);
            end
            if (rsp_ch.free_slots !== want.free_slots) begin
               mismatches++;
               $display("%0t ns: free_slots expected %0d actual %0d", $time,
                        want.free_slots, rsp_ch.free_slots);
            end
            if (rsp_ch.total_slots !== want.total_slots) begin
               mismatches++;
               $display("%0t ns: total_slots expected %0d actual %0d", $time,
                        want.total_slots, rsp_ch.total_slots);
            end
            if (want.created) slots_created++;
            if (want.status == STATUS_FULL) full_seen++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Straight out of reset the table is empty: rejects, idle mode, and growth by
   // appending, including a release of a slot that is already free.
   task automatic test_empty_table();
      send_request(MODE_RELEASE, 16'd0, 6'd0);
      send_request(MODE_BEST_FIT, 16'd0, 6'd0);
      send_request(MODE_NOP, 16'hA5C3, 6'h2A);
      send_request(MODE_FIRST_FIT, 16'd0, 6'd0);
      send_request(MODE_BEST_FIT, 16'hFFFF, 6'h3F);
      send_request(MODE_RELEASE, 16'hFFFF, 6'd1);
      send_request(MODE_RELEASE, 16'd0, 6'd1);
      send_request(MODE_FIRST_FIT, 16'hFFFF, 6'd0);
      send_request(MODE_RELEASE, 16'd0, 6'd63);
   endtask

   // A slot count above the table size saturates to a full table of the
   // widest capacity; quotients span from one to the largest value.
   task automatic test_saturated_rebuild();
      set_pool(127, 16'hFFFF);
      send_request(MODE_BEST_FIT, 16'd1, 6'd0);
      send_request(MODE_BEST_FIT, 16'hFFFF, 6'd0);
      send_request(MODE_FIRST_FIT, 16'hFFFF, 6'd0);
   endtask

   // Full table of zero-capacity slots: nothing fits, nothing can be appended,
   // but a zero-length first fit still takes the first free slot.
   task automatic test_full_table();
      set_pool(MAX_SLOTS, 0);
      send_request(MODE_BEST_FIT, 16'd5, 6'd0);
      send_request(MODE_FIRST_FIT, 16'hFFFF, 6'd0);
      send_request(MODE_FIRST_FIT, 16'd0, 6'd0);
      send_request(MODE_RELEASE, 16'd0, 6'd63);
      send_request(MODE_RELEASE, 16'd0, 6'd0);
   endtask

   // First fit of the widest length appends a slot whose capacity saturates.
   task automatic test_appended_saturation();
      set_pool(0, 7);
      send_request(MODE_FIRST_FIT, 16'hFFFF, 6'd0);
      send_request(MODE_RELEASE, 16'd0, 6'd0);
      send_request(MODE_BEST_FIT, 16'hFFFF, 6'd0);
   endtask

   // Equal quotients go to the lowest index; a larger appended slot loses to
   // smaller ones once released.
   task automatic test_best_fit_ties();
      set_pool(3, 10);
      send_request(MODE_BEST_FIT, 16'd4, 6'd0);
      send_request(MODE_FIRST_FIT, 16'd11, 6'd0);
      send_request(MODE_RELEASE, 16'd0, 6'd3);
      send_request(MODE_BEST_FIT, 16'd3, 6'd0);
   endtask

   // Random traffic over several table settings, the extremes first. Amounts
   // cluster around the slot capacity so that fits, ties and misses all occur.
   task automatic test_random_traffic();
      int unsigned slots, cap, lim, pick;
      mode_type    m;
      logic [AMOUNT_W-1:0]     amt;
      logic [SLOT_INDEX_W-1:0] idx;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin slots = MAX_SLOTS; cap = 16'hFFFF; end
            1: begin slots = 0; cap = 1; end
            2: begin slots = 1; cap = $urandom_range(1, 300); end
            3: begin slots = $urandom_range(65, 127); cap = $urandom_range(1, 40); end
            default: begin
               slots = $urandom_range(0, MAX_SLOTS);
               cap   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16'hFFFF)
                                                   : $urandom_range(1, 200);
            end
         endcase
         set_pool(slots, cap);
         repeat (ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 38)      m = MODE_BEST_FIT;
            else if (pick < 70) m = MODE_FIRST_FIT;
            else if (pick < 96) m = MODE_RELEASE;
            else                m = MODE_NOP;
            lim  = (2 * cfg_cap + 2 > 16'hFFFF) ? 16'hFFFF : 2 * cfg_cap + 2;
            pick = $urandom_range(0, 99);
            if (pick < 6)       amt = '0;
            else if (pick < 60) amt = AMOUNT_W'($urandom_range(1, lim));
            else if (pick < 80) amt = AMOUNT_W'($urandom_range(1, 64));
            else                amt = AMOUNT_W'($urandom);
            lim = (pool_total + 1 > MAX_SLOTS - 1) ? MAX_SLOTS - 1 : pool_total + 1;
            if ($urandom_range(0, 99) < 85) idx = SLOT_INDEX_W'($urandom_range(0, lim));
            else                            idx = SLOT_INDEX_W'($urandom);
            send_request(m, amt, idx);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      req_ch.valid      = 1'b0;
      req_ch.mode       = MODE_BEST_FIT;
      req_ch.amount     = '0;
      req_ch.slot_index = '0;
      mismatches        = 0;
      responses_checked = 0;
      best_fit_sent     = 0;
      first_fit_sent    = 0;
      release_sent      = 0;
      nop_sent          = 0;
      slots_created     = 0;
      full_seen         = 0;
      burst_left        = 0;
      // Reset state of the model: empty table, registers at their reset values.
      cfg_slots         = CFG_SLOTS_RESET;
      cfg_cap           = CFG_CAP_RESET;
      pool_total        = 0;
      pool_free_cnt     = 0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         pool_cap[i]  = '0;
         pool_free[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_saturated_rebuild();
      test_full_table();
      test_appended_saturation();
      test_best_fit_ties();
      test_random_traffic();

      // Let the last responses come back, then watch for strays.
      drain_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d best-fit, %0d first-fit, %0d release, %0d idle requests",
               best_fit_sent, first_fit_sent, release_sent, nop_sent);
      $display("checked %0d responses: %0d appended slots, %0d table-full rejects",
               responses_checked, slots_created, full_seen);
      if (mismatches == 0 && pending_grants.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
